@@ hdl/cmp_pkg.sv @@
// shared types, constants and helpers of the coap message parser
package cmp_pkg;

    localparam int MAX_MESSAGE_BYTES = 1024;
    localparam int IDX_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LVL_W = 3;
    localparam int TDATA_W = 152;

    localparam logic [7:0] MARKER_BYTE = 8'hFF;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_TOKEN   = 4'd1,
        PH_OPT_HDR = 4'd2,
        PH_EXT_LEN = 4'd3,
        PH_VALUE   = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_DISCARD = 4'd6
    } t_phase;

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_OPTION  = 3'd1,
        K_END     = 3'd2,
        K_END_PAY = 3'd3,
        K_ERROR   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_SHORT_HDR = 3'd0,
        ST_BAD_VER   = 3'd1,
        ST_BAD_PKT   = 3'd2,
        ST_BAD_OPT   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    localparam logic [15:0] OPT_URI_HOST = 16'd3;
    localparam logic [15:0] OPT_URI_PORT = 16'd7;
    localparam logic [15:0] OPT_URI_PATH = 16'd11;
    localparam logic [15:0] OPT_CFORMAT  = 16'd12;
    localparam logic [15:0] OPT_URI_QRY  = 16'd15;
    localparam logic [15:0] OPT_ACCEPT   = 16'd17;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] msg_id;
        logic [3:0]  tok_len;
        logic [63:0] token_value;
        logic [15:0] option_number;
        logic [8:0]  opt_len;
        logic [10:0] value_offset;
        logic [15:0] uint_value;
        logic [2:0]  status;
        logic        last;
    } t_result;

    // queue status seen by the front and by the checks
    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               room;
    } t_q_status;

    // option check: duplicates of single options, length limits, known numbers
    function automatic logic option_ok(input logic [15:0] num, input logic [8:0] len,
                                       input logic [3:0] delta);
        logic single;
        logic ok;
        single = (num == 16'd3) || (num == 16'd5) || (num == 16'd7) || (num == 16'd12) ||
                 (num == 16'd14) || (num == 16'd17) || (num == 16'd35) ||
                 (num == 16'd39) || (num == 16'd60);
        ok = 1'b0;
        if (num == OPT_URI_HOST) ok = (len >= 9'd1) && (len <= 9'd255);
        else if (num == OPT_URI_PATH || num == OPT_URI_QRY) ok = (len <= 9'd255);
        else if (num == OPT_URI_PORT || num == OPT_CFORMAT || num == OPT_ACCEPT)
            ok = (len <= 9'd2);
        return ok && !(single && delta == 4'd0);
    endfunction

endpackage

@@ hdl/cmp_front.sv @@
// byte parser front: tracks message state and forms up to two results per byte
module cmp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic [1:0]        o_count,
    output cmp_pkg::t_result  o_res0,
    output cmp_pkg::t_result  o_res1
);
    import cmp_pkg::*;

    t_phase          r_phase, n_phase;
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [1:0]      r_version, n_version;
    logic [1:0]      r_header_type, n_header_type;
    logic [7:0]      r_header_code, n_header_code;
    logic [15:0]     r_header_id, n_header_id;
    logic [3:0]      r_token_count, n_token_count;
    logic [63:0]     r_token_acc, n_token_acc;
    logic [15:0]     r_current_option, n_current_option;
    logic [3:0]      r_current_delta, n_current_delta;
    logic [8:0]      r_value_length, n_value_length;
    logic [8:0]      r_bytes_left, n_bytes_left;
    logic [15:0]     r_value_acc, n_value_acc;
    logic [10:0]     r_value_start, n_value_start;

    t_result         res [2];
    logic [1:0]      cnt;
    logic            do_start;
    logic            do_finish;
    logic [10:0]     next_off;
    logic            too_long;

    assign next_off = 11'({1'b0, r_byte_index} + 1'b1);
    assign too_long = (r_byte_index >= IDX_W'(MAX_MESSAGE_BYTES));

    // next state and results of the current byte
    always_comb begin
        n_phase = r_phase;
        n_byte_index = r_byte_index;
        n_version = r_version;
        n_header_type = r_header_type;
        n_header_code = r_header_code;
        n_header_id = r_header_id;
        n_token_count = r_token_count;
        n_token_acc = r_token_acc;
        n_current_option = r_current_option;
        n_current_delta = r_current_delta;
        n_value_length = r_value_length;
        n_bytes_left = r_bytes_left;
        n_value_acc = r_value_acc;
        n_value_start = r_value_start;
        res[0] = '0;
        res[1] = '0;
        cnt = 2'd0;
        do_start = 1'b0;
        do_finish = 1'b0;

        if (r_phase != PH_PAYLOAD && r_phase != PH_DISCARD && too_long) begin
            res[cnt[0]].kind = K_ERROR;
            res[cnt[0]].status = ST_TOO_LONG;
            cnt = cnt + 2'd1;
            n_phase = PH_DISCARD;
        end else begin
            unique case (r_phase)
                PH_HEAD: begin
                    if (r_byte_index == IDX_W'(0)) begin
                        n_version = i_byte[7:6];
                        n_header_type = i_byte[5:4];
                        n_token_count = i_byte[3:0];
                    end else if (r_byte_index == IDX_W'(1)) begin
                        n_header_code = i_byte;
                    end else if (r_byte_index == IDX_W'(2)) begin
                        n_header_id = {i_byte, 8'h00};
                    end else begin
                        n_header_id = {r_header_id[15:8], i_byte};
                        if (r_version != 2'd1) begin
                            res[cnt[0]].kind = K_ERROR;
                            res[cnt[0]].status = ST_BAD_VER;
                            cnt = cnt + 2'd1;
                            n_phase = PH_DISCARD;
                        end else if (r_token_count >= 4'd9) begin
                            res[cnt[0]].kind = K_ERROR;
                            res[cnt[0]].status = ST_BAD_PKT;
                            cnt = cnt + 2'd1;
                            n_phase = PH_DISCARD;
                        end else if (r_token_count == 4'd0) begin
                            res[cnt[0]].kind = K_HEADER;
                            res[cnt[0]].msg_type = r_header_type;
                            res[cnt[0]].msg_code = r_header_code;
                            res[cnt[0]].msg_id = n_header_id;
                            res[cnt[0]].tok_len = r_token_count;
                            res[cnt[0]].token_value = r_token_acc;
                            cnt = cnt + 2'd1;
                            n_phase = PH_OPT_HDR;
                        end else begin
                            n_bytes_left = {5'd0, r_token_count};
                            n_token_acc = '0;
                            n_phase = PH_TOKEN;
                        end
                    end
                end
                PH_TOKEN: begin
                    n_token_acc = {r_token_acc[55:0], i_byte};
                    n_bytes_left = r_bytes_left - 9'd1;
                    if (n_bytes_left == 9'd0) begin
                        res[cnt[0]].kind = K_HEADER;
                        res[cnt[0]].msg_type = r_header_type;
                        res[cnt[0]].msg_code = r_header_code;
                        res[cnt[0]].msg_id = r_header_id;
                        res[cnt[0]].tok_len = r_token_count;
                        res[cnt[0]].token_value = n_token_acc;
                        cnt = cnt + 2'd1;
                        n_phase = PH_OPT_HDR;
                    end
                end
                PH_OPT_HDR: begin
                    if (i_byte == MARKER_BYTE) begin
                        if (i_last) begin
                            res[cnt[0]].kind = K_ERROR;
                            res[cnt[0]].status = ST_BAD_PKT;
                            cnt = cnt + 2'd1;
                            n_phase = PH_DISCARD;
                        end else begin
                            res[cnt[0]].kind = K_END_PAY;
                            res[cnt[0]].value_offset = next_off;
                            cnt = cnt + 2'd1;
                            n_phase = PH_PAYLOAD;
                        end
                    end else if (i_byte[7:4] >= 4'd13 || i_byte[3:0] >= 4'd14) begin
                        res[cnt[0]].kind = K_ERROR;
                        res[cnt[0]].status = ST_BAD_PKT;
                        cnt = cnt + 2'd1;
                        n_phase = PH_DISCARD;
                    end else begin
                        n_current_delta = i_byte[7:4];
                        if (i_byte[3:0] == 4'd13) begin
                            n_phase = PH_EXT_LEN;
                        end else begin
                            n_value_length = {5'd0, i_byte[3:0]};
                            do_start = 1'b1;
                        end
                    end
                end
                PH_EXT_LEN: begin
                    n_value_length = {1'b0, i_byte} + 9'd13;
                    do_start = 1'b1;
                end
                PH_VALUE: begin
                    n_value_acc = {r_value_acc[7:0], i_byte};
                    n_bytes_left = r_bytes_left - 9'd1;
                    if (n_bytes_left == 9'd0) do_finish = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // open the option value
        if (do_start) begin
            n_current_option = r_current_option + {12'd0, n_current_delta};
            n_value_start = next_off;
            n_bytes_left = n_value_length;
            n_value_acc = '0;
            if (n_value_length == 9'd0) do_finish = 1'b1;
            else n_phase = PH_VALUE;
        end

        // close the option value
        if (do_finish) begin
            n_phase = PH_OPT_HDR;
            if (option_ok(n_current_option, n_value_length, n_current_delta)) begin
                res[cnt[0]].kind = K_OPTION;
                res[cnt[0]].option_number = n_current_option;
                res[cnt[0]].opt_len = n_value_length;
                res[cnt[0]].value_offset = n_value_start;
                if (n_current_option == OPT_URI_PORT || n_current_option == OPT_CFORMAT ||
                    n_current_option == OPT_ACCEPT)
                    res[cnt[0]].uint_value = n_value_acc;
                cnt = cnt + 2'd1;
            end else if (n_current_option[0]) begin
                res[cnt[0]].kind = K_ERROR;
                res[cnt[0]].status = ST_BAD_OPT;
                cnt = cnt + 2'd1;
                n_phase = PH_DISCARD;
            end
        end

        // end of message
        if (i_last) begin
            if (n_phase == PH_OPT_HDR) begin
                res[cnt[0]].kind = K_END;
                cnt = cnt + 2'd1;
            end else if (n_phase == PH_HEAD) begin
                res[cnt[0]].kind = K_ERROR;
                res[cnt[0]].status = ST_SHORT_HDR;
                cnt = cnt + 2'd1;
            end else if (n_phase == PH_TOKEN || n_phase == PH_EXT_LEN ||
                         n_phase == PH_VALUE) begin
                res[cnt[0]].kind = K_ERROR;
                res[cnt[0]].status = ST_BAD_PKT;
                cnt = cnt + 2'd1;
            end
            n_phase = PH_HEAD;
            n_byte_index = '0;
            n_version = '0;
            n_header_type = '0;
            n_header_code = '0;
            n_header_id = '0;
            n_token_count = '0;
            n_token_acc = '0;
            n_current_option = '0;
            n_current_delta = '0;
            n_value_length = '0;
            n_bytes_left = '0;
            n_value_acc = '0;
            n_value_start = '0;
        end else if (!too_long) begin
            n_byte_index = r_byte_index + 1'b1;
        end

        // mark the final result of this byte
        if (cnt == 2'd1) res[0].last = 1'b1;
        else if (cnt == 2'd2) res[1].last = 1'b1;
    end

    assign o_count = i_accept ? cnt : 2'd0;
    assign o_res0 = res[0];
    assign o_res1 = res[1];

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_byte_index <= '0;
            r_version <= '0;
            r_header_type <= '0;
            r_header_code <= '0;
            r_header_id <= '0;
            r_token_count <= '0;
            r_token_acc <= '0;
            r_current_option <= '0;
            r_current_delta <= '0;
            r_value_length <= '0;
            r_bytes_left <= '0;
            r_value_acc <= '0;
            r_value_start <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_byte_index <= n_byte_index;
            r_version <= n_version;
            r_header_type <= n_header_type;
            r_header_code <= n_header_code;
            r_header_id <= n_header_id;
            r_token_count <= n_token_count;
            r_token_acc <= n_token_acc;
            r_current_option <= n_current_option;
            r_current_delta <= n_current_delta;
            r_value_length <= n_value_length;
            r_bytes_left <= n_bytes_left;
            r_value_acc <= n_value_acc;
            r_value_start <= n_value_start;
        end
    end

endmodule

@@ hdl/cmp_back.sv @@
// result queue and output side: takes up to two results a cycle, sends one while i_ready is high
module cmp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_count,
    input  cmp_pkg::t_result       i_res0,
    input  cmp_pkg::t_result       i_res1,
    input  logic                   i_ready,
    output logic                   o_valid,
    output cmp_pkg::t_result       o_res,
    output cmp_pkg::t_q_status     o_status
);
    import cmp_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_LVL_W-1:0]   r_level, n_level;
    logic                 pop;

    assign o_valid = (r_level != '0);
    assign o_res = r_mem[r_rd];
    assign pop = o_valid && i_ready;
    assign o_status.level = r_level;
    assign o_status.room = (r_level <= Q_LVL_W'(Q_DEPTH - 2));

    // pointers and fill level
    always_comb begin
        n_wr = r_wr + Q_PTR_W'(i_count);
        n_rd = r_rd + Q_PTR_W'(pop);
        n_level = r_level + Q_LVL_W'(i_count) - Q_LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_level <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_level <= n_level;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wr] <= i_res0;
        if (i_count == 2'd2) r_mem[r_wr + Q_PTR_W'(1)] <= i_res1;
    end

endmodule

@@ hdl/coap_message_parser_unit.sv @@
// coap message parser top level: byte stream in, result stream out
// the results of a byte are registered in the result queue before they are offered
// throughput: one byte per cycle while the four-entry result queue holds two results
// or fewer; the input stalls while it holds three or more, as a byte may yield two
// reset: synchronous active-low i_rst_n clears parser state and empties the queue
module coap_message_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // data_byte
    input  logic                          i_s_tlast,  // last_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // msg_type, msg_code, msg_id, tok_len, token_value, option_number,
    // opt_len, value_offset, uint_value, status, zero fill
    output logic [cmp_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [2:0]                    o_m_tuser,  // kind
    output logic                          o_m_tlast   // last
);
    import cmp_pkg::*;

    logic       accept;
    logic [1:0] count;
    t_result    res0, res1, out_res;
    t_q_status  q_status;

    assign o_s_tready = q_status.room;
    assign accept = i_s_tvalid && o_s_tready;

    cmp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_count  (count),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    cmp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_count  (count),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_res    (out_res),
        .o_status (q_status)
    );

    // pack the result transaction
    assign o_m_tdata = {3'd0, out_res.status, out_res.uint_value, out_res.value_offset,
                        out_res.opt_len, out_res.option_number, out_res.token_value,
                        out_res.tok_len, out_res.msg_id, out_res.msg_code,
                        out_res.msg_type};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

`ifndef SYNTHESIS
    // queue never overfills
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= Q_LVL_W'(Q_DEPTH))
        else $error("result queue overfilled");

    // output valid tracks queue occupancy
    a_valid_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid == (q_status.level != '0))
        else $error("output valid disagrees with queue level");

    // a pushed pair of results with no pop in that cycle is visible in the level next cycle
    a_push_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (count == 2'd2 && !(o_m_tvalid && i_m_tready)) |=>
        q_status.level == $past(q_status.level) + Q_LVL_W'(2))
        else $error("result pair not queued");
`endif

endmodule
